FILE: rtl/core/rnrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnrs_pkg
// Shared types and constants for the road relay selector: field widths,
// register indexes, search modes and the sequencer step codes.
// ----------------------------------------------------------------------------
package rnrs_pkg;

  // Neighbor id width
  localparam int unsigned IdBits = 8;

  // Input field widths
  localparam int unsigned PosBits  = 16;
  localparam int unsigned VelBits  = 14;
  localparam int unsigned CfgBits  = 16;
  localparam int unsigned ModeBits = 2;

  // Shared multiplier operand and product widths
  localparam int unsigned MulBits  = 32;
  localparam int unsigned ProdBits = 2 * MulBits;

  // Intermediate widths, set by the input ranges
  localparam int unsigned D2Bits  = 32;  // dx^2 + dy^2 and R^2
  localparam int unsigned SBits   = 28;  // dvx^2 + dvy^2
  localparam int unsigned PcBits  = 31;  // signed dot and cross products
  localparam int unsigned WideBits = 60; // S*R^2, C^2 and their difference
  localparam int unsigned ABits   = 45;  // signed min_time*S + 16*P
  localparam int unsigned ALoBits = 32;  // low part of A
  localparam int unsigned AHiBits = 12;  // high part of positive A
  localparam int unsigned SqBits  = 88;  // A^2

  // Configuration register indexes
  typedef enum logic [0:0] {
    CfgRangeLimit  = 1'b0,
    CfgMinLinkTime = 1'b1
  } cfg_idx_e;

  localparam logic [CfgBits-1:0] RangeLimitReset  = 16'd3200;
  localparam logic [CfgBits-1:0] MinLinkTimeReset = 16'd16;

  // Search modes; any other code searches both directions
  localparam logic [ModeBits-1:0] ModeBoth    = 2'd0;
  localparam logic [ModeBits-1:0] ModeFwdOnly = 2'd1;
  localparam logic [ModeBits-1:0] ModeRevOnly = 2'd2;

  // Sequencer steps; each step issues at most one product
  typedef enum logic [4:0] {
    StepDxSq  = 5'd0,
    StepDySq  = 5'd1,
    StepRSq   = 5'd2,
    StepDyVx  = 5'd3,
    StepDxVy  = 5'd4,
    StepVxSq  = 5'd5,
    StepVySq  = 5'd6,
    StepDxVx  = 5'd7,
    StepCSq   = 5'd8,
    StepDyVy  = 5'd9,
    StepSR2   = 5'd10,
    StepMinS  = 5'd11,
    StepDd    = 5'd12,
    StepAlSq  = 5'd13,
    StepAlAh  = 5'd14,
    StepAhSq  = 5'd15,
    StepFinish = 5'd16
  } step_e;

  // Request into the shared multiplier
  typedef struct packed {
    logic               valid;
    step_e              tag;
    logic               neg;
    logic [MulBits-1:0] op_a;
    logic [MulBits-1:0] op_b;
  } mul_req_t;

  // Registered product out of the shared multiplier
  typedef struct packed {
    logic                valid;
    step_e               tag;
    logic                neg;
    logic [ProdBits-1:0] prod;
  } mul_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/core/rnrs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnrs_if
// Valid/ready channels of the road relay selector: the neighbor beat in and
// the relay result beat out.
// ----------------------------------------------------------------------------
interface rnrs_nbr_if;
  logic                                 valid;
  logic                                 ready;
  logic [rnrs_pkg::IdBits-1:0]          neighbor_id;
  logic signed [rnrs_pkg::PosBits-1:0]  rel_pos_x;
  logic signed [rnrs_pkg::PosBits-1:0]  rel_pos_y;
  logic signed [rnrs_pkg::VelBits-1:0]  rel_vel_x;
  logic signed [rnrs_pkg::VelBits-1:0]  rel_vel_y;
  logic [rnrs_pkg::ModeBits-1:0]        search_mode;
  logic                                 last_neighbor;

  modport source (
    output valid, neighbor_id, rel_pos_x, rel_pos_y, rel_vel_x, rel_vel_y,
           search_mode, last_neighbor,
    input  ready
  );
  modport sink (
    input  valid, neighbor_id, rel_pos_x, rel_pos_y, rel_vel_x, rel_vel_y,
           search_mode, last_neighbor,
    output ready
  );
endinterface

interface rnrs_relay_if;
  logic                        valid;
  logic                        ready;
  logic                        forward_found;
  logic [rnrs_pkg::IdBits-1:0] forward_id;
  logic                        reverse_found;
  logic [rnrs_pkg::IdBits-1:0] reverse_id;

  modport source (
    output valid, forward_found, forward_id, reverse_found, reverse_id,
    input  ready
  );
  modport sink (
    input  valid, forward_found, forward_id, reverse_found, reverse_id,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/core/rnrs_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnrs_mul
// Shared 32x32 unsigned multiplier with a registered product. The step tag
// and sign travel with the product so the caller knows where to fold it.
// ----------------------------------------------------------------------------
module rnrs_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  rnrs_pkg::mul_req_t      req_i,
  output rnrs_pkg::mul_rsp_t      rsp_o
);

  logic                          valid_q;
  rnrs_pkg::step_e               tag_q;
  logic                          neg_q;
  logic [rnrs_pkg::ProdBits-1:0] prod_q;

  // Track which products are real
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= req_i.valid;
    end
  end

  // Register the product with its tag and sign
  always_ff @(posedge clk_i) begin
    tag_q  <= req_i.tag;
    neg_q  <= req_i.neg;
    prod_q <= req_i.op_a * req_i.op_b;
  end

  assign rsp_o.valid = valid_q;
  assign rsp_o.tag   = tag_q;
  assign rsp_o.neg   = neg_q;
  assign rsp_o.prod  = prod_q;

endmodule
`default_nettype wire

FILE: rtl/core/road_neighbor_relay_select.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// road_neighbor_relay_select
// Filters offered neighbors by range and link expiry time and keeps the
// farthest eligible neighbor ahead and behind along the road; reports the
// winners on the last neighbor of a round.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  nbr_i     in   valid/ready         id, rel pos x/y, rel vel x/y, mode, last
//  relay_o   out  valid/ready         forward found/id, reverse found/id
//  cfg       in   cfg_we_i            cfg_idx_i, cfg_wdata_i (write only)
//
//  After its accept, each neighbor beat runs through 17 sequencer steps (15
//  issue one product into the shared 32x32 multiplier, the other two settle
//  the range test and the last product), then a decision state before the
//  next accept.
//  nbr_i.ready is high only while the sequencer is idle.
//  A round's result sits in an output register; the decision cycle of the
//  next last neighbor waits while that register is still full.
//  Reset clears the selection store and loads the register defaults.
// ----------------------------------------------------------------------------
module road_neighbor_relay_select (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [rnrs_pkg::CfgBits-1:0]   cfg_wdata_i,
  rnrs_nbr_if.sink                            nbr_i,
  rnrs_relay_if.source                        relay_o
);

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StRun    = 3'b010,
    StDecide = 3'b100
  } state_e;

  localparam int unsigned IdW   = rnrs_pkg::IdBits;
  localparam int unsigned PosW  = rnrs_pkg::PosBits;
  localparam int unsigned VelW  = rnrs_pkg::VelBits;
  localparam int unsigned MulW  = rnrs_pkg::MulBits;
  localparam int unsigned D2W   = rnrs_pkg::D2Bits;
  localparam int unsigned SW    = rnrs_pkg::SBits;
  localparam int unsigned PcW   = rnrs_pkg::PcBits;
  localparam int unsigned WideW = rnrs_pkg::WideBits;
  localparam int unsigned AW    = rnrs_pkg::ABits;
  localparam int unsigned ALoW  = rnrs_pkg::ALoBits;
  localparam int unsigned AHiW  = rnrs_pkg::AHiBits;
  localparam int unsigned SqW   = rnrs_pkg::SqBits;

  // Configuration registers
  logic [rnrs_pkg::CfgBits-1:0] range_limit_q;
  logic [rnrs_pkg::CfgBits-1:0] min_link_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_limit_q   <= rnrs_pkg::RangeLimitReset;
      min_link_time_q <= rnrs_pkg::MinLinkTimeReset;
    end else if (cfg_we_i) begin
      unique case (rnrs_pkg::cfg_idx_e'(cfg_idx_i))
        rnrs_pkg::CfgRangeLimit:  range_limit_q   <= cfg_wdata_i;
        rnrs_pkg::CfgMinLinkTime: min_link_time_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  state_e          state_q, state_d;
  rnrs_pkg::step_e step_q, step_d;
  logic            nbr_fire;
  logic            relay_fire;
  logic            out_valid_q;
  logic            last_q;
  logic            dec_go;

  assign nbr_fire   = nbr_i.valid && nbr_i.ready;
  assign relay_fire = out_valid_q && relay_o.ready;
  assign dec_go     = (state_q == StDecide) && !(last_q && out_valid_q && !relay_o.ready);
  assign nbr_i.ready = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        if (nbr_fire) begin
          state_d = StRun;
          step_d  = rnrs_pkg::StepDxSq;
        end
      end
      StRun: begin
        if (step_q == rnrs_pkg::StepFinish) begin
          state_d = StDecide;
        end else begin
          step_d = rnrs_pkg::step_e'(step_q + 5'd1);
        end
      end
      StDecide: begin
        if (dec_go) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= rnrs_pkg::StepDxSq;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Capture the neighbor beat as magnitudes and signs
  logic [IdW-1:0]                id_q;
  logic [PosW-1:0]               dx_mag_q, dy_mag_q;
  logic                          dx_neg_q, dy_neg_q;
  logic [VelW-1:0]               vx_mag_q, vy_mag_q;
  logic                          vx_neg_q, vy_neg_q;
  logic [rnrs_pkg::ModeBits-1:0] mode_q;

  always_ff @(posedge clk_i) begin
    if (nbr_fire) begin
      id_q     <= nbr_i.neighbor_id;
      dx_neg_q <= nbr_i.rel_pos_x[PosW-1];
      dy_neg_q <= nbr_i.rel_pos_y[PosW-1];
      vx_neg_q <= nbr_i.rel_vel_x[VelW-1];
      vy_neg_q <= nbr_i.rel_vel_y[VelW-1];
      dx_mag_q <= nbr_i.rel_pos_x[PosW-1] ? PosW'(-nbr_i.rel_pos_x) : nbr_i.rel_pos_x;
      dy_mag_q <= nbr_i.rel_pos_y[PosW-1] ? PosW'(-nbr_i.rel_pos_y) : nbr_i.rel_pos_y;
      vx_mag_q <= nbr_i.rel_vel_x[VelW-1] ? VelW'(-nbr_i.rel_vel_x) : nbr_i.rel_vel_x;
      vy_mag_q <= nbr_i.rel_vel_y[VelW-1] ? VelW'(-nbr_i.rel_vel_y) : nbr_i.rel_vel_y;
      mode_q   <= nbr_i.search_mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else if (nbr_fire) begin
      last_q <= nbr_i.last_neighbor;
    end
  end

  // Working registers
  logic [D2W-1:0]          d2_q, r2_q;
  logic [SW-1:0]           s_q;
  logic signed [PcW-1:0]   p_q, c_q;
  logic [WideW-1:0]        c2_q, sr2_q, dd_q;
  logic signed [AW-1:0]    a_q;
  logic [SqW-1:0]          sq_q;
  logic                    range_ok_q;
  logic [PcW-2:0]          c_mag;
  logic [ALoW-1:0]         a_lo;
  logic [AHiW-1:0]         a_hi;

  assign c_mag = c_q[PcW-1] ? (PcW-1)'(-c_q) : c_q[PcW-2:0];
  assign a_lo  = a_q[ALoW-1:0];
  assign a_hi  = a_q[ALoW+AHiW-1:ALoW];

  // Pick the operands of this step's product
  rnrs_pkg::mul_req_t mul_req;
  rnrs_pkg::mul_rsp_t mul_rsp;

  always_comb begin
    mul_req.valid = (state_q == StRun);
    mul_req.tag   = step_q;
    mul_req.neg   = 1'b0;
    mul_req.op_a  = '0;
    mul_req.op_b  = '0;
    unique case (step_q)
      rnrs_pkg::StepDxSq: begin
        mul_req.op_a = MulW'(dx_mag_q);
        mul_req.op_b = MulW'(dx_mag_q);
      end
      rnrs_pkg::StepDySq: begin
        mul_req.op_a = MulW'(dy_mag_q);
        mul_req.op_b = MulW'(dy_mag_q);
      end
      rnrs_pkg::StepRSq: begin
        mul_req.op_a = MulW'(range_limit_q);
        mul_req.op_b = MulW'(range_limit_q);
      end
      rnrs_pkg::StepDyVx: begin
        mul_req.op_a = MulW'(dy_mag_q);
        mul_req.op_b = MulW'(vx_mag_q);
        mul_req.neg  = dy_neg_q ^ vx_neg_q;
      end
      rnrs_pkg::StepDxVy: begin
        // enters the cross product with a minus sign
        mul_req.op_a = MulW'(dx_mag_q);
        mul_req.op_b = MulW'(vy_mag_q);
        mul_req.neg  = !(dx_neg_q ^ vy_neg_q);
      end
      rnrs_pkg::StepVxSq: begin
        mul_req.op_a = MulW'(vx_mag_q);
        mul_req.op_b = MulW'(vx_mag_q);
      end
      rnrs_pkg::StepVySq: begin
        mul_req.op_a = MulW'(vy_mag_q);
        mul_req.op_b = MulW'(vy_mag_q);
      end
      rnrs_pkg::StepDxVx: begin
        mul_req.op_a = MulW'(dx_mag_q);
        mul_req.op_b = MulW'(vx_mag_q);
        mul_req.neg  = dx_neg_q ^ vx_neg_q;
      end
      rnrs_pkg::StepCSq: begin
        mul_req.op_a = MulW'(c_mag);
        mul_req.op_b = MulW'(c_mag);
      end
      rnrs_pkg::StepDyVy: begin
        mul_req.op_a = MulW'(dy_mag_q);
        mul_req.op_b = MulW'(vy_mag_q);
        mul_req.neg  = dy_neg_q ^ vy_neg_q;
      end
      rnrs_pkg::StepSR2: begin
        mul_req.op_a = MulW'(s_q);
        mul_req.op_b = MulW'(r2_q);
      end
      rnrs_pkg::StepMinS: begin
        mul_req.op_a = MulW'(min_link_time_q);
        mul_req.op_b = MulW'(s_q);
      end
      rnrs_pkg::StepAlSq: begin
        mul_req.op_a = a_lo;
        mul_req.op_b = a_lo;
      end
      rnrs_pkg::StepAlAh: begin
        mul_req.op_a = a_lo;
        mul_req.op_b = MulW'(a_hi);
      end
      rnrs_pkg::StepAhSq: begin
        mul_req.op_a = MulW'(a_hi);
        mul_req.op_b = MulW'(a_hi);
      end
      rnrs_pkg::StepDd, rnrs_pkg::StepFinish: begin
        mul_req.valid = 1'b0;
      end
      default: mul_req.valid = 1'b0;
    endcase
  end

  rnrs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Fold each registered product into its target
  always_ff @(posedge clk_i) begin
    if (mul_rsp.valid) begin
      case (mul_rsp.tag)
        rnrs_pkg::StepDxSq: d2_q <= mul_rsp.prod[D2W-1:0];
        rnrs_pkg::StepDySq: d2_q <= d2_q + mul_rsp.prod[D2W-1:0];
        rnrs_pkg::StepRSq:  r2_q <= mul_rsp.prod[D2W-1:0];
        rnrs_pkg::StepDyVx: begin
          c_q <= mul_rsp.neg ? PcW'(0) - $signed(mul_rsp.prod[PcW-1:0])
                             : $signed(mul_rsp.prod[PcW-1:0]);
        end
        rnrs_pkg::StepDxVy: begin
          c_q <= mul_rsp.neg ? c_q - $signed(mul_rsp.prod[PcW-1:0])
                             : c_q + $signed(mul_rsp.prod[PcW-1:0]);
        end
        rnrs_pkg::StepVxSq: s_q <= mul_rsp.prod[SW-1:0];
        rnrs_pkg::StepVySq: s_q <= s_q + mul_rsp.prod[SW-1:0];
        rnrs_pkg::StepDxVx: begin
          p_q <= mul_rsp.neg ? PcW'(0) - $signed(mul_rsp.prod[PcW-1:0])
                             : $signed(mul_rsp.prod[PcW-1:0]);
        end
        rnrs_pkg::StepCSq:  c2_q <= mul_rsp.prod[WideW-1:0];
        rnrs_pkg::StepDyVy: begin
          p_q <= mul_rsp.neg ? p_q - $signed(mul_rsp.prod[PcW-1:0])
                             : p_q + $signed(mul_rsp.prod[PcW-1:0]);
        end
        rnrs_pkg::StepSR2:  sr2_q <= mul_rsp.prod[WideW-1:0];
        rnrs_pkg::StepMinS: begin
          a_q <= $signed({{(AW-PcW-4){p_q[PcW-1]}}, p_q, 4'b0000})
               + $signed({1'b0, mul_rsp.prod[AW-2:0]});
        end
        rnrs_pkg::StepAlSq: sq_q <= SqW'(mul_rsp.prod);
        rnrs_pkg::StepAlAh: begin
          sq_q <= sq_q + {mul_rsp.prod[SqW-ALoW-2:0], {(ALoW+1){1'b0}}};
        end
        rnrs_pkg::StepAhSq: begin
          sq_q <= sq_q + {mul_rsp.prod[SqW-2*ALoW-1:0], {(2*ALoW){1'b0}}};
        end
        default: ;
      endcase
    end
    // Range test and the discriminant, once their inputs are settled
    if (state_q == StRun && step_q == rnrs_pkg::StepDd) begin
      range_ok_q <= (d2_q <= r2_q);
      dd_q       <= (sr2_q > c2_q) ? sr2_q - c2_q : '0;
    end
  end

  // Eligibility decision
  logic a_pos, s_zero, below, eligible;
  assign a_pos    = !a_q[AW-1] && (a_q != '0);
  assign s_zero   = (s_q == '0);
  assign below    = {{(SqW-WideW-8){1'b0}}, dd_q, 8'b0} < sq_q;
  assign eligible = range_ok_q && (s_zero || !a_pos || !below);

  // Selection store
  logic [PosW-1:0] best_fwd_dist_q, best_rev_dist_q;
  logic [IdW-1:0]  best_fwd_node_q, best_rev_node_q;
  logic            fwd_valid_q, rev_valid_q;
  logic            fwd_win, rev_win;
  logic            want_fwd, want_rev;
  logic            fwd_found, rev_found;

  assign fwd_win  = eligible && !dx_neg_q && (dx_mag_q > best_fwd_dist_q);
  assign rev_win  = eligible && dx_neg_q && (dx_mag_q > best_rev_dist_q);
  assign want_fwd = (mode_q != rnrs_pkg::ModeRevOnly);
  assign want_rev = (mode_q != rnrs_pkg::ModeFwdOnly);
  assign fwd_found = want_fwd && (fwd_valid_q || fwd_win);
  assign rev_found = want_rev && (rev_valid_q || rev_win);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_fwd_dist_q <= '0;
      best_fwd_node_q <= '0;
      fwd_valid_q     <= 1'b0;
      best_rev_dist_q <= '0;
      best_rev_node_q <= '0;
      rev_valid_q     <= 1'b0;
    end else if (dec_go) begin
      if (last_q) begin
        // round ends: drop all winners
        best_fwd_dist_q <= '0;
        best_fwd_node_q <= '0;
        fwd_valid_q     <= 1'b0;
        best_rev_dist_q <= '0;
        best_rev_node_q <= '0;
        rev_valid_q     <= 1'b0;
      end else begin
        if (fwd_win) begin
          best_fwd_dist_q <= dx_mag_q;
          best_fwd_node_q <= id_q;
          fwd_valid_q     <= 1'b1;
        end
        if (rev_win) begin
          best_rev_dist_q <= dx_mag_q;
          best_rev_node_q <= id_q;
          rev_valid_q     <= 1'b1;
        end
      end
    end
  end

  // Result register
  logic           fwd_found_q, rev_found_q;
  logic [IdW-1:0] fwd_id_q, rev_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dec_go && last_q) begin
      out_valid_q <= 1'b1;
    end else if (relay_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_go && last_q) begin
      fwd_found_q <= fwd_found;
      rev_found_q <= rev_found;
      fwd_id_q    <= fwd_found ? (fwd_win ? id_q : best_fwd_node_q) : '0;
      rev_id_q    <= rev_found ? (rev_win ? id_q : best_rev_node_q) : '0;
    end
  end

  assign relay_o.valid         = out_valid_q;
  assign relay_o.forward_found = fwd_found_q;
  assign relay_o.forward_id    = fwd_id_q;
  assign relay_o.reverse_found = rev_found_q;
  assign relay_o.reverse_id    = rev_id_q;

  // Checks
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(dec_go && last_q))
    else $error("result raised without a finished last neighbor");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec_go && last_q) |=> (!fwd_valid_q && !rev_valid_q))
    else $error("store not cleared after round");

  a_fwd_dist_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_valid_q == (best_fwd_dist_q != '0))
    else $error("forward valid disagrees with stored distance");

  a_rev_dist_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rev_valid_q == (best_rev_dist_q != '0))
    else $error("reverse valid disagrees with stored distance");

  a_no_drop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !relay_o.ready) |=> out_valid_q)
    else $error("result lost while stalled");

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Directed and randomized handshake test of the road relay selector. A built-in
// predictor applies the range and link expiry filters and the farthest-neighbor
// choice per direction, and each relay beat is checked against it in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned IdleLimit    = 5000;
  localparam int unsigned HoldCycles   = 600;
  localparam int unsigned SettleCycles = 40;
  // Unnamed mode code; the block searches both directions for it
  localparam logic [rnrs_pkg::ModeBits-1:0] ModeBothAlt = 2'd3;

  typedef struct packed {
    logic [rnrs_pkg::IdBits-1:0]   id;
    logic [rnrs_pkg::PosBits-1:0]  pos_x;
    logic [rnrs_pkg::PosBits-1:0]  pos_y;
    logic [rnrs_pkg::VelBits-1:0]  vel_x;
    logic [rnrs_pkg::VelBits-1:0]  vel_y;
    logic [rnrs_pkg::ModeBits-1:0] mode;
    logic                          last;
  } nbr_beat_t;

  typedef struct packed {
    logic                        fwd_found;
    logic [rnrs_pkg::IdBits-1:0] fwd_id;
    logic                        rev_found;
    logic [rnrs_pkg::IdBits-1:0] rev_id;
  } relay_t;

  typedef enum logic [1:0] {SinkOpen, SinkCoin, SinkMostly, SinkSparse} sink_pat_e;

  logic                         clk_i     = 1'b0;
  logic                         rst_ni    = 1'b1;
  logic                         cfg_we    = 1'b0;
  rnrs_pkg::cfg_idx_e           cfg_idx   = rnrs_pkg::CfgRangeLimit;
  logic [rnrs_pkg::CfgBits-1:0] cfg_wdata = '0;

  rnrs_nbr_if   nbr_if ();
  rnrs_relay_if relay_if ();

  road_neighbor_relay_select DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .nbr_i      (nbr_if),
    .relay_o    (relay_if)
  );

  // Register copy and selection store of the predictor
  logic [rnrs_pkg::CfgBits-1:0] range_cfg     = rnrs_pkg::RangeLimitReset;
  logic [rnrs_pkg::CfgBits-1:0] min_time_cfg  = rnrs_pkg::MinLinkTimeReset;
  logic [rnrs_pkg::PosBits-1:0] fwd_best_dist = '0;
  logic [rnrs_pkg::PosBits-1:0] rev_best_dist = '0;
  logic [rnrs_pkg::IdBits-1:0]  fwd_best_id   = '0;
  logic [rnrs_pkg::IdBits-1:0]  rev_best_id   = '0;
  logic                         fwd_seen      = 1'b0;
  logic                         rev_seen      = 1'b0;

  nbr_beat_t nbr_pending[$];
  relay_t    relays_due[$];

  int error_count   = 0;
  int beats_in      = 0;
  int relays_out    = 0;
  int drop_count    = 0;
  int fwd_wins      = 0;
  int rev_wins      = 0;
  int settings_seen = 1;
  int hold_req      = 0;
  int hold_seen;

  int unsigned burst_left, gap_left;
  int unsigned pat_left, hold_left, idle_cycles;
  sink_pat_e   sink_pat;
  nbr_beat_t   drv_beat, mon_beat;
  relay_t      want, due, got;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Range test, then link expiry against the minimum, all in exact integers
  function automatic bit link_holds(input nbr_beat_t b);
    longint dx, dy, vx, vy, r2, d2, s, p, c, c2, sr2, dd, a;
    logic [127:0] dd_w, a_w;
    dx = longint'($signed(b.pos_x));
    dy = longint'($signed(b.pos_y));
    vx = longint'($signed(b.vel_x));
    vy = longint'($signed(b.vel_y));
    r2 = longint'(range_cfg) * longint'(range_cfg);
    d2 = dx * dx + dy * dy;
    if (d2 > r2) return 1'b0;
    s = vx * vx + vy * vy;
    // No relative motion: the link never expires
    if (s == 0) return 1'b1;
    p   = dx * vx + dy * vy;
    c   = dy * vx - dx * vy;
    c2  = c * c;
    sr2 = s * r2;
    dd  = (sr2 > c2) ? sr2 - c2 : 0;
    a   = longint'(min_time_cfg) * s + 16 * p;
    if (a <= 0) return 1'b1;
    dd_w = 128'(dd) << 8;
    a_w  = 128'(a);
    return !(dd_w < a_w * a_w);
  endfunction

  // Update the store with one neighbor; on the last one build the relay beat
  function automatic bit select_relay(input nbr_beat_t b, output relay_t r);
    logic [rnrs_pkg::PosBits-1:0] road_dist;
    r = '0;
    if (link_holds(b)) begin
      road_dist = b.pos_x[rnrs_pkg::PosBits-1] ? (~b.pos_x + 1'b1) : b.pos_x;
      if (!b.pos_x[rnrs_pkg::PosBits-1]) begin
        if (road_dist > fwd_best_dist) begin
          fwd_best_dist = road_dist;
          fwd_best_id   = b.id;
          fwd_seen      = 1'b1;
        end
      end else if (road_dist > rev_best_dist) begin
        rev_best_dist = road_dist;
        rev_best_id   = b.id;
        rev_seen      = 1'b1;
      end
    end else begin
      drop_count++;
    end
    if (!b.last) return 1'b0;
    r.fwd_found = (b.mode != rnrs_pkg::ModeRevOnly) && fwd_seen;
    r.fwd_id    = r.fwd_found ? fwd_best_id : '0;
    r.rev_found = (b.mode != rnrs_pkg::ModeFwdOnly) && rev_seen;
    r.rev_id    = r.rev_found ? rev_best_id : '0;
    fwd_best_dist = '0;
    fwd_best_id   = '0;
    fwd_seen      = 1'b0;
    rev_best_dist = '0;
    rev_best_id   = '0;
    rev_seen      = 1'b0;
    return 1'b1;
  endfunction

  function automatic void push_nbr(input logic [rnrs_pkg::IdBits-1:0] id,
                                   input int dx, input int dy,
                                   input int vx, input int vy,
                                   input logic [rnrs_pkg::ModeBits-1:0] mode,
                                   input logic last);
    nbr_beat_t b;
    b.id    = id;
    b.pos_x = rnrs_pkg::PosBits'(dx);
    b.pos_y = rnrs_pkg::PosBits'(dy);
    b.vel_x = rnrs_pkg::VelBits'(vx);
    b.vel_y = rnrs_pkg::VelBits'(vy);
    b.mode  = mode;
    b.last  = last;
    nbr_pending.insert(nbr_pending.size(), b);
  endfunction

  // Rounds of one to eight neighbors, mostly placed around the range circle
  task automatic push_random_rounds(input int unsigned n_items);
    int unsigned pushed, len, span;
    int dx, dy, vx, vy, prev_dx;
    pushed  = 0;
    prev_dx = 0;
    span    = (range_cfg > 26000) ? 32767 : range_cfg + range_cfg / 4 + 1;
    while (pushed < n_items) begin
      len = $urandom_range(1, 8);
      for (int j = 0; j < len; j++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: begin
            dx = int'($urandom_range(0, 2 * span)) - int'(span);
            dy = int'($urandom_range(0, span)) - int'(span / 2);
          end
          7, 8: begin
            dx = $signed(rnrs_pkg::PosBits'($urandom));
            dy = $signed(rnrs_pkg::PosBits'($urandom));
          end
          default: begin
            dx = int'($urandom_range(0, 2 * span)) - int'(span);
            dy = int'($urandom_range(0, span)) - int'(span / 2);
            case ($urandom_range(0, 3))
              0: dx = 0;
              1: dy = 0;
              2: dx = -32768;
              default: dx = 32767;
            endcase
          end
        endcase
        // Repeat the last road distance now and then to provoke ties
        if ($urandom_range(0, 9) == 0) dx = ($urandom_range(0, 1) != 0) ? prev_dx : -prev_dx;
        prev_dx = dx;
        case ($urandom_range(0, 9))
          0, 1: begin
            vx = 0;
            vy = 0;
          end
          2, 3, 4, 5, 6: begin
            vx = int'($urandom_range(0, 800)) - 400;
            vy = int'($urandom_range(0, 200)) - 100;
          end
          default: begin
            vx = $signed(rnrs_pkg::VelBits'($urandom));
            vy = $signed(rnrs_pkg::VelBits'($urandom));
          end
        endcase
        push_nbr(rnrs_pkg::IdBits'($urandom), dx, dy, vx, vy,
                 rnrs_pkg::ModeBits'($urandom_range(0, 3)), j == len - 1);
        pushed++;
      end
    end
  endtask

  // Hold until every queued beat is in and every round has reported
  task automatic wait_drained();
    while (nbr_pending.size() != 0 || nbr_if.valid || relays_due.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input rnrs_pkg::cfg_idx_e idx,
                           input logic [rnrs_pkg::CfgBits-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    if (idx == rnrs_pkg::CfgRangeLimit) range_cfg = val;
    else min_time_cfg = val;
  endtask

  task automatic apply_cfg(input logic [rnrs_pkg::CfgBits-1:0] range_val,
                           input logic [rnrs_pkg::CfgBits-1:0] min_val);
    write_cfg(rnrs_pkg::CfgRangeLimit, range_val);
    write_cfg(rnrs_pkg::CfgMinLinkTime, min_val);
    settings_seen++;
  endtask

  // Stimulus: directed rounds, then random rounds over several settings
  initial begin
    #1 rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Standing still ahead, on the side axis, a tie, far behind, out of range,
    // and exactly on the range circle
    push_nbr(8'h11, 100, 0, 0, 0, rnrs_pkg::ModeBoth, 1'b0);
    push_nbr(8'h22, 0, 50, 0, 0, rnrs_pkg::ModeBoth, 1'b0);
    push_nbr(8'h33, 100, 10, 0, 0, rnrs_pkg::ModeBoth, 1'b0);
    push_nbr(8'h44, -3000, 0, 0, 0, rnrs_pkg::ModeBoth, 1'b0);
    push_nbr(8'hFF, 32767, -32768, 8191, -8192, rnrs_pkg::ModeBoth, 1'b0);
    push_nbr(8'h00, -3200, 0, 0, 0, rnrs_pkg::ModeBoth, 1'b1);
    // Forward only: leaving the range slowly, leaving too soon, fast reverse
    push_nbr(8'h55, 3000, 0, 160, 0, rnrs_pkg::ModeBoth, 1'b0);
    push_nbr(8'h66, 3100, 0, 160, 0, rnrs_pkg::ModeBoth, 1'b0);
    push_nbr(8'h77, -1000, 0, -8192, 8191, rnrs_pkg::ModeFwdOnly, 1'b1);
    // Reverse only, with a forward winner that must not show
    push_nbr(8'h88, 2000, 0, 0, 0, rnrs_pkg::ModeBoth, 1'b0);
    push_nbr(8'h99, -2000, 100, 5000, 0, rnrs_pkg::ModeRevOnly, 1'b1);
    // Unnamed mode: closing in just enough to keep the link, then a fast pass
    push_nbr(8'hAA, 1, 0, -1, 0, rnrs_pkg::ModeBoth, 1'b0);
    push_nbr(8'hBB, -1, -1, 8191, 8191, ModeBothAlt, 1'b1);
    // No winner in either direction
    push_nbr(8'hCC, -32768, 32767, -8192, 8191, rnrs_pkg::ModeBoth, 1'b0);
    push_nbr(8'hDD, 0, 0, 0, 0, rnrs_pkg::ModeBoth, 1'b1);
    push_nbr(8'hEE, 0, -20, 0, 0, ModeBothAlt, 1'b1);
    wait_drained();

    push_random_rounds(180);
    wait_drained();

    apply_cfg(16'hFFFF, 16'h0000);
    push_random_rounds(180);
    wait_drained();

    apply_cfg(16'hFFFF, 16'hFFFF);
    push_random_rounds(150);
    wait_drained();

    apply_cfg(16'h0000, 16'h0000);
    push_random_rounds(60);
    wait_drained();

    apply_cfg(16'h0000, 16'hFFFF);
    push_random_rounds(30);
    wait_drained();

    apply_cfg(rnrs_pkg::CfgBits'($urandom_range(400, 6000)),
              rnrs_pkg::CfgBits'($urandom_range(0, 160)));
    push_random_rounds(200);
    // Stall the result side for a long stretch while rounds keep arriving
    hold_req++;
    push_random_rounds(60);
    wait_drained();

    apply_cfg(rnrs_pkg::CfgBits'($urandom_range(1, 65535)),
              rnrs_pkg::CfgBits'($urandom_range(0, 65535)));
    push_random_rounds(150);
    wait_drained();

    $display("Covered %0d neighbor beats and %0d relay beats over %0d register settings.",
             beats_in, relays_out, settings_seen);
    $display("Dropped neighbors: %0d; forward relays reported: %0d; reverse: %0d.",
             drop_count, fwd_wins, rev_wins);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Neighbor driver: bursts of beats with random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nbr_if.valid         <= 1'b0;
      nbr_if.neighbor_id   <= '0;
      nbr_if.rel_pos_x     <= '0;
      nbr_if.rel_pos_y     <= '0;
      nbr_if.rel_vel_x     <= '0;
      nbr_if.rel_vel_y     <= '0;
      nbr_if.search_mode   <= '0;
      nbr_if.last_neighbor <= 1'b0;
      burst_left           <= 0;
      gap_left             <= 0;
    end else if (!nbr_if.valid || nbr_if.ready) begin
      if (gap_left != 0) begin
        gap_left     <= gap_left - 1;
        nbr_if.valid <= 1'b0;
      end else if (nbr_pending.size() != 0) begin
        drv_beat = nbr_pending.pop_front();
        nbr_if.valid         <= 1'b1;
        nbr_if.neighbor_id   <= drv_beat.id;
        nbr_if.rel_pos_x     <= drv_beat.pos_x;
        nbr_if.rel_pos_y     <= drv_beat.pos_y;
        nbr_if.rel_vel_x     <= drv_beat.vel_x;
        nbr_if.rel_vel_y     <= drv_beat.vel_y;
        nbr_if.search_mode   <= drv_beat.mode;
        nbr_if.last_neighbor <= drv_beat.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        nbr_if.valid <= 1'b0;
      end
    end
  end

  // Relay receiver: changing stall patterns, plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_if.ready <= 1'b0;
      sink_pat       <= SinkOpen;
      pat_left       <= 0;
      hold_left      <= 0;
      hold_seen      <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen      <= hold_req;
      hold_left      <= HoldCycles;
      relay_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      relay_if.ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        sink_pat <= sink_pat_e'($urandom_range(0, 3));
        pat_left <= $urandom_range(20, 200);
      end else begin
        pat_left <= pat_left - 1;
      end
      case (sink_pat)
        SinkOpen:   relay_if.ready <= 1'b1;
        SinkCoin:   relay_if.ready <= ($urandom_range(0, 1) != 0);
        SinkMostly: relay_if.ready <= ($urandom_range(0, 7) != 0);
        default:    relay_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Monitor: predict on each neighbor beat, check each relay beat, watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if (nbr_if.valid && nbr_if.ready) begin
        mon_beat.id    = nbr_if.neighbor_id;
        mon_beat.pos_x = nbr_if.rel_pos_x;
        mon_beat.pos_y = nbr_if.rel_pos_y;
        mon_beat.vel_x = nbr_if.rel_vel_x;
        mon_beat.vel_y = nbr_if.rel_vel_y;
        mon_beat.mode  = nbr_if.search_mode;
        mon_beat.last  = nbr_if.last_neighbor;
        beats_in++;
        if (select_relay(mon_beat, want)) relays_due.insert(relays_due.size(), want);
      end
      if (relay_if.valid && relay_if.ready) begin
        got.fwd_found = relay_if.forward_found;
        got.fwd_id    = relay_if.forward_id;
        got.rev_found = relay_if.reverse_found;
        got.rev_id    = relay_if.reverse_id;
        relays_out++;
        if (relays_due.size() == 0) begin
          error_count++;
          $error("relay beat with no closed round waiting");
        end else begin
          due = relays_due.pop_front();
          if (due.fwd_found) fwd_wins++;
          if (due.rev_found) rev_wins++;
          if (got.fwd_found !== due.fwd_found) begin
            error_count++;
            $error("forward_found: expected %0d, got %0d", due.fwd_found, got.fwd_found);
          end
          if (got.fwd_id !== due.fwd_id) begin
            error_count++;
            $error("forward_id: expected %0d, got %0d", due.fwd_id, got.fwd_id);
          end
          if (got.rev_found !== due.rev_found) begin
            error_count++;
            $error("reverse_found: expected %0d, got %0d", due.rev_found, got.rev_found);
          end
          if (got.rev_id !== due.rev_id) begin
            error_count++;
            $error("reverse_id: expected %0d, got %0d", due.rev_id, got.rev_id);
          end
        end
      end
      if ((nbr_if.valid && nbr_if.ready) || (relay_if.valid && relay_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no beat moved for %0d cycles", IdleLimit);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
